// ===== sv/sfs_pkg.sv =====
`timescale 1ns / 1ps

package sfs_pkg;

    // fixed field widths
    localparam int DELTA_W     = 20;
    localparam int FRAME_IDX_W = 16;
    localparam int RECT_W      = 28;
    localparam int DUR_W       = 32;
    localparam int CNT_W       = 16;
    localparam int PIX_W       = 13;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd6;

    // request action codes
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic {
        OP_DIV,
        OP_SCALE
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_DIV,
        AS_DBL,
        AS_ADD
    } t_alu_state;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_TIME,
        SQ_TIME_W,
        SQ_GAP,
        SQ_DELTA_W,
        SQ_ADD,
        SQ_SCALE,
        SQ_SCALE_W,
        SQ_COLS,
        SQ_COLS_W,
        SQ_MUL_X,
        SQ_MUL_Y,
        SQ_OUT
    } t_seq_state;

endpackage

// ===== sv/sfs_if.sv =====
`timescale 1ns / 1ps

interface sfs_req_if;
    import sfs_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [DELTA_W-1:0] delta_ticks;

    modport source (output valid, output action, output delta_ticks, input ready);
    modport sink   (input valid, input action, input delta_ticks, output ready);
endinterface

interface sfs_res_if;
    import sfs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [RECT_W-1:0]      rect_x;
    logic [RECT_W-1:0]      rect_y;
    logic                   anim_ended;

    modport source (output valid, output frame_index, output rect_x, output rect_y,
                    output anim_ended, input ready);
    modport sink   (input valid, input frame_index, input rect_x, input rect_y,
                    input anim_ended, output ready);
endinterface

// ===== sv/sfs_alu.sv =====
`timescale 1ns / 1ps

// Shared bit-serial unit: restoring division (one quotient bit per cycle) or
// floor(t * n / d) for t <= d (a doubling step per bit of n, plus an add step per set bit).
module sfs_alu #(
    parameter int AW         = 32,
    parameter int FRAME_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sfs_pkg::t_alu_ctl        i_ctl,
    input  logic [AW-1:0]            i_a,
    input  logic [AW-1:0]            i_b,
    input  logic [FRAME_BITS-1:0]    i_n,
    input  logic [$clog2(AW)-1:0]    i_top,
    output logic                     o_done,
    output logic [AW-1:0]            o_rem,
    output logic [AW-1:0]            o_quo
);
    import sfs_pkg::*;

    localparam int IW = $clog2(AW);

    t_alu_state            r_state, n_state;
    logic [AW-1:0]         r_a;
    logic [AW-1:0]         r_div;
    logic [AW-1:0]         r_dmt;
    logic [FRAME_BITS-1:0] r_n;
    logic [AW-1:0]         r_rem;
    logic [AW-1:0]         r_quo;
    logic [IW-1:0]         r_idx;
    logic                  r_done;

    logic [AW:0] sub_x;
    logic [AW:0] sub_y;
    logic [AW:0] diff;
    logic        ge;
    logic        nbit;
    logic        last;
    logic        adv;

    assign nbit = r_n[FRAME_BITS-1];
    assign diff = sub_x - sub_y;
    assign ge   = (sub_x >= sub_y);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            AS_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_ctl.op == OP_DIV) ? AS_DIV : AS_DBL;
                end
            end
            AS_DIV: begin
                if (r_idx == '0) n_state = AS_IDLE;
            end
            AS_DBL: begin
                if (nbit) begin
                    n_state = AS_ADD;
                end else if (r_idx == '0) begin
                    n_state = AS_IDLE;
                end
            end
            AS_ADD: begin
                n_state = (r_idx == '0) ? AS_IDLE : AS_DBL;
            end
            default: n_state = AS_IDLE;
        endcase
    end

    // operand select and step control
    always_comb begin
        sub_x = '0;
        sub_y = '0;
        last  = 1'b0;
        adv   = 1'b0;
        case (r_state)
            AS_DIV: begin
                sub_x = {r_rem, r_a[r_idx]};
                sub_y = {1'b0, r_div};
                last  = (r_idx == '0);
            end
            AS_DBL: begin
                sub_x = {r_rem, 1'b0};
                sub_y = {1'b0, r_div};
                last  = !nbit && (r_idx == '0);
                adv   = !nbit;
            end
            AS_ADD: begin
                sub_x = {1'b0, r_rem};
                sub_y = {1'b0, r_dmt};
                last  = (r_idx == '0);
                adv   = 1'b1;
            end
            default: begin
                sub_x = '0;
                sub_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            AS_IDLE: begin
                if (i_ctl.start) begin
                    r_rem <= '0;
                    r_quo <= '0;
                    r_a   <= i_a;
                    r_div <= i_b;
                    r_dmt <= i_b - i_a;
                    r_n   <= i_n;
                    r_idx <= (i_ctl.op == OP_DIV) ? i_top : IW'(FRAME_BITS - 1);
                end
            end
            AS_DIV, AS_DBL: begin
                // 2r (plus next dividend bit) reduced by the divisor
                r_rem <= ge ? diff[AW-1:0] : sub_x[AW-1:0];
                r_quo <= {r_quo[AW-2:0], ge};
            end
            AS_ADD: begin
                // r >= d - t is the same test as r + t >= d
                if (ge) begin
                    r_rem <= diff[AW-1:0];
                    r_quo <= r_quo + AW'(1);
                end else begin
                    r_rem <= r_rem + r_a;
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
        if (r_state == AS_DIV || adv) begin
            r_idx <= r_idx - IW'(1);
        end
        if (adv) begin
            r_n <= {r_n[FRAME_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

// ===== sv/sprite_frame_sequencer.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                        Handshake
// i_req     in   action, delta_ticks                            valid/ready
// o_res     out  frame_index, rect_x, rect_y, anim_ended        valid/ready
// i_cfg_*   in   register index, write data                     write enable
//
// An advance holds the request channel (ready low) from accept until its result
// is loaded into the output register; the work runs in the shared bit-serial
// divide/scale unit, its sequencer and one shared multiplier. In loop mode the
// unit first reduces the stored time modulo the duration when it is at or past
// the duration, and delta_ticks likewise when it is at or past the duration.
// Restart and disabled requests leave the block idle. Reset is synchronous, active
// low; the output register holds a result under stall while the next request
// is already taken.
module sprite_frame_sequencer #(
    parameter int TIME_BITS  = 32,
    parameter int FRAME_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfs_req_if.sink                        i_req,
    sfs_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfs_pkg::*;

    localparam int CW = (TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W;
    localparam int AW = (CW > FRAME_BITS) ? CW : FRAME_BITS;
    localparam int IW = $clog2(AW);
    localparam int MW = (CNT_W > FRAME_BITS) ? CNT_W : FRAME_BITS;

    // configuration
    logic             r_enabled;
    logic             r_loop;
    logic [DUR_W-1:0] r_duration;
    logic [CNT_W-1:0] r_frames;
    logic [CNT_W-1:0] r_cols;
    logic [PIX_W-1:0] r_fw;
    logic [PIX_W-1:0] r_fh;

    // sequencer and working state
    t_seq_state              r_state, n_state;
    logic [TIME_BITS-1:0]    r_elapsed;
    logic                    r_ended;
    logic [DELTA_W-1:0]      r_delta;
    logic [TIME_BITS-1:0]    r_gap;
    logic [CW-1:0]           r_dm;
    logic [FRAME_BITS-1:0]   r_frame;
    logic [CNT_W-1:0]        r_col;
    logic [FRAME_BITS-1:0]   r_row;
    logic [RECT_W-1:0]       r_rect_x;
    logic [RECT_W-1:0]       r_rect_y;

    // output register
    logic                    r_out_valid;
    logic [FRAME_IDX_W-1:0]  r_out_frame;
    logic [RECT_W-1:0]       r_out_x;
    logic [RECT_W-1:0]       r_out_y;
    logic                    r_out_ended;

    // derived operands
    logic [TIME_BITS+DUR_W-1:0]     d_ext;
    logic [TIME_BITS-1:0]           dur;
    logic [FRAME_BITS+CNT_W-1:0]    n_ext;
    logic [FRAME_BITS-1:0]          nfr;
    logic [CNT_W-1:0]               cols;
    logic                           time_wrap;
    logic                           delta_wrap;
    logic [CW:0]                    sum;
    logic [FRAME_BITS-1:0]          q;
    logic [MW-1:0]                  mul_a;
    logic [PIX_W-1:0]               mul_b;
    logic [MW+PIX_W-1:0]            prod;
    logic [RECT_W+MW+PIX_W-1:0]     prod_ext;
    logic [RECT_W-1:0]              rect;
    logic [FRAME_IDX_W+FRAME_BITS-1:0] f_ext;

    logic                    ready_c;
    logic                    req_acc;
    logic                    out_load;
    t_alu_ctl                alu_ctl;
    logic [AW-1:0]           alu_a;
    logic [AW-1:0]           alu_b;
    logic [IW-1:0]           alu_top;
    logic                    alu_done;
    logic [AW-1:0]           alu_rem;
    logic [AW-1:0]           alu_quo;

    assign d_ext = {TIME_BITS'(0), r_duration};
    assign dur   = (d_ext[TIME_BITS-1:0] == '0) ? TIME_BITS'(1) : d_ext[TIME_BITS-1:0];
    assign n_ext = {FRAME_BITS'(0), r_frames};
    assign nfr   = (n_ext[FRAME_BITS-1:0] == '0) ? FRAME_BITS'(1) : n_ext[FRAME_BITS-1:0];
    assign cols  = (r_cols == '0) ? CNT_W'(1) : r_cols;

    assign time_wrap  = r_loop && (r_elapsed >= dur);
    assign delta_wrap = r_loop && !r_ended && (CW'(r_delta) >= CW'(dur));
    assign sum        = {1'b0, CW'(r_elapsed)} + {1'b0, r_dm};
    assign q          = alu_quo[FRAME_BITS-1:0];

    // one multiplier, shared by both rectangle coordinates
    assign mul_a    = (r_state == SQ_MUL_X) ? MW'(r_col) : MW'(r_row);
    assign mul_b    = (r_state == SQ_MUL_X) ? r_fw : r_fh;
    assign prod     = mul_a * mul_b;
    assign prod_ext = {RECT_W'(0), prod};
    assign rect     = prod_ext[RECT_W-1:0];
    assign f_ext    = {FRAME_IDX_W'(0), r_frame};

    assign req_acc  = i_req.valid && ready_c;
    assign out_load = (r_state == SQ_OUT) && (!r_out_valid || o_res.ready);

    sfs_alu #(
        .AW         (AW),
        .FRAME_BITS (FRAME_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_n     (nfr),
        .i_top   (alu_top),
        .o_done  (alu_done),
        .o_rem   (alu_rem),
        .o_quo   (alu_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE: begin
                if (req_acc && r_enabled && (i_req.action == ACT_ADVANCE)) begin
                    n_state = SQ_TIME;
                end
            end
            SQ_TIME:    n_state = time_wrap ? SQ_TIME_W : SQ_GAP;
            SQ_TIME_W:  if (alu_done) n_state = SQ_GAP;
            SQ_GAP: begin
                if (r_ended) begin
                    n_state = SQ_SCALE;
                end else if (delta_wrap) begin
                    n_state = SQ_DELTA_W;
                end else begin
                    n_state = SQ_ADD;
                end
            end
            SQ_DELTA_W: if (alu_done) n_state = SQ_ADD;
            SQ_ADD:     n_state = SQ_SCALE;
            SQ_SCALE:   n_state = SQ_SCALE_W;
            SQ_SCALE_W: if (alu_done) n_state = SQ_COLS;
            SQ_COLS:    n_state = SQ_COLS_W;
            SQ_COLS_W:  if (alu_done) n_state = SQ_MUL_X;
            SQ_MUL_X:   n_state = SQ_MUL_Y;
            SQ_MUL_Y:   n_state = SQ_OUT;
            SQ_OUT:     if (out_load) n_state = SQ_IDLE;
            default:    n_state = SQ_IDLE;
        endcase
    end

    // outputs of the sequencer: ready and requests to the shared unit
    always_comb begin
        ready_c       = (r_state == SQ_IDLE);
        alu_ctl.start = 1'b0;
        alu_ctl.op    = OP_DIV;
        alu_a         = '0;
        alu_b         = AW'(dur);
        alu_top       = IW'(TIME_BITS - 1);
        case (r_state)
            SQ_TIME: begin
                alu_ctl.start = time_wrap;
                alu_a         = AW'(r_elapsed);
            end
            SQ_GAP: begin
                alu_ctl.start = !r_ended && delta_wrap;
                alu_a         = AW'(r_delta);
                alu_top       = IW'(DELTA_W - 1);
            end
            SQ_SCALE: begin
                alu_ctl.start = 1'b1;
                alu_ctl.op    = OP_SCALE;
                alu_a         = AW'(r_elapsed);
            end
            SQ_COLS: begin
                alu_ctl.start = 1'b1;
                alu_a         = AW'(r_frame);
                alu_b         = AW'(cols);
                alu_top       = IW'(FRAME_BITS - 1);
            end
            default: begin
                alu_ctl.start = 1'b0;
            end
        endcase
    end

    assign i_req.ready = ready_c;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_loop     <= 1'b0;
            r_duration <= DUR_W'(1);
            r_frames   <= CNT_W'(1);
            r_cols     <= CNT_W'(1);
            r_fw       <= PIX_W'(1);
            r_fh       <= PIX_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ANIM_ENABLED:   r_enabled  <= i_cfg_data[0];
                CFG_LOOP_MODE:      r_loop     <= i_cfg_data[0];
                CFG_DURATION_TICKS: r_duration <= i_cfg_data[DUR_W-1:0];
                CFG_TOTAL_FRAMES:   r_frames   <= i_cfg_data[CNT_W-1:0];
                CFG_SHEET_COLUMNS:  r_cols     <= i_cfg_data[CNT_W-1:0];
                CFG_FRAME_WIDTH:    r_fw       <= i_cfg_data[PIX_W-1:0];
                CFG_FRAME_HEIGHT:   r_fh       <= i_cfg_data[PIX_W-1:0];
                default:            r_enabled  <= r_enabled;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // animation time and ended flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_ended   <= 1'b0;
        end else begin
            case (r_state)
                SQ_IDLE: begin
                    if (req_acc && r_enabled && (i_req.action == ACT_RESTART)) begin
                        r_elapsed <= '0;
                        r_ended   <= 1'b0;
                    end
                end
                SQ_TIME: begin
                    // one-shot: time saturates at the duration
                    if (!r_loop && (r_elapsed > dur)) r_elapsed <= dur;
                end
                SQ_TIME_W: begin
                    if (alu_done) r_elapsed <= alu_rem[TIME_BITS-1:0];
                end
                SQ_ADD: begin
                    if (r_dm >= CW'(r_gap)) begin
                        r_elapsed <= r_loop ? sum[TIME_BITS-1:0] - dur : dur;
                    end else begin
                        r_elapsed <= sum[TIME_BITS-1:0];
                    end
                end
                SQ_SCALE_W: begin
                    if (alu_done && !r_loop && (q >= nfr)) r_ended <= 1'b1;
                end
                default: begin
                    r_ended <= r_ended;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_delta <= i_req.delta_ticks;
        end
        case (r_state)
            SQ_GAP: begin
                r_gap <= dur - r_elapsed;
                r_dm  <= CW'(r_delta);
            end
            SQ_DELTA_W: begin
                if (alu_done) r_dm <= alu_rem[CW-1:0];
            end
            SQ_SCALE_W: begin
                if (alu_done) begin
                    r_frame <= (!r_loop && (q >= nfr)) ? nfr - FRAME_BITS'(1) : q;
                end
            end
            SQ_COLS_W: begin
                if (alu_done) begin
                    r_col <= alu_rem[CNT_W-1:0];
                    r_row <= alu_quo[FRAME_BITS-1:0];
                end
            end
            SQ_MUL_X: r_rect_x <= rect;
            SQ_MUL_Y: r_rect_y <= rect;
            default: begin
                r_gap <= r_gap;
            end
        endcase
        if (out_load) begin
            r_out_frame <= f_ext[FRAME_IDX_W-1:0];
            r_out_x     <= r_rect_x;
            r_out_y     <= r_rect_y;
            r_out_ended <= r_ended;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.frame_index = r_out_frame;
    assign o_res.rect_x      = r_out_x;
    assign o_res.rect_y      = r_out_y;
    assign o_res.anim_ended  = r_out_ended;

endmodule

// ===== sv/sfs_checker.sv =====
`timescale 1ns / 1ps

module sfs_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    input  logic                           i_req_action,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [sfs_pkg::FRAME_IDX_W-1:0] i_res_frame_index,
    input  logic [sfs_pkg::RECT_W-1:0]     i_res_rect_x,
    input  logic [sfs_pkg::RECT_W-1:0]     i_res_rect_y,
    input  logic                           i_res_anim_ended,
    input  logic                           i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfs_pkg::*;

    logic r_en;
    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    // enable as seen on the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_ANIM_ENABLED)) begin
            r_en <= i_cfg_data[0];
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_frame_index)
            && $stable(i_res_rect_x) && $stable(i_res_rect_y) && $stable(i_res_anim_ended))
        else $error("result changed while stalled");

    a_advance_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && r_en && (i_req_action == ACT_ADVANCE) |=> !i_req_ready)
        else $error("request taken during an advance");

    a_no_work_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && !(r_en && (i_req_action == ACT_ADVANCE)) |=> i_req_ready)
        else $error("restart or disabled request left the block busy");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && i_req_ready)
        else $error("block not idle after reset");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_action      (i_req.action),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_frame_index (o_res.frame_index),
    .i_res_rect_x      (o_res.rect_x),
    .i_res_rect_y      (o_res.rect_y),
    .i_res_anim_ended  (o_res.anim_ended),
    .i_cfg_we          (i_cfg_we),
    .i_cfg_idx         (i_cfg_idx),
    .i_cfg_data        (i_cfg_data)
);
